// ===== sv/sorted_list_engine_unit_defines.svh =====
// Assertion macros shared by the sorted list engine.
`ifndef SORTED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_LIST_ENGINE_UNIT_DEFINES_SVH

// Condition must hold in the same cycle as the trigger.
`define SLE_ASSERT_SAME(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("sorted list engine: same-cycle check failed");

// Condition must hold in the cycle after the trigger.
`define SLE_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("sorted list engine: next-cycle check failed");

`endif

// ===== sv/sle_pkg.sv =====
`default_nettype none

package sle_pkg;

  // Default number of list cells.
  parameter int CAPACITY_DEF = 16;

  // Fixed field widths of the request and result.
  localparam int CMD_W   = 2;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic [VALUE_W-1:0] value;
  } cell_ctl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               valid;
    logic               lt;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== sv/sle_if.sv =====
`default_nettype none

// Request channel: command and value.
interface sle_in_if;
  logic                          valid;
  logic                          ready;
  logic [sle_pkg::CMD_W-1:0]     cmd;
  logic signed [sle_pkg::VALUE_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel.
interface sle_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ok;
  logic [sle_pkg::POS_W-1:0]     position;
  logic [sle_pkg::COUNT_W-1:0]   count;
  logic                          empty_res;

  modport source (output valid, output ok, output position, output count,
                  output empty_res, input ready);
  modport sink   (input valid, input ok, input position, input count,
                  input empty_res, output ready);
endinterface

`default_nettype wire

// ===== sv/sle_cell.sv =====
`default_nettype none

// One slot of the sorted list. It compares its entry with the request value
// and, on an update, keeps its entry, takes the request value or takes one from a neighbor.
module sle_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire sle_pkg::cell_ctl_t   ctl,
  input  wire sle_pkg::cell_stat_t  left,
  input  wire sle_pkg::cell_stat_t  right,
  output sle_pkg::cell_stat_t       stat,
  output logic                      hit
);

  logic [sle_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic                        valid_r, valid_nxt;
  logic                        lt;
  logic                        boundary;

  // Entry is stored and orders below the request value.
  assign lt       = valid_r & ($signed(value_r) < $signed(ctl.value));
  // First slot that is not below the request value.
  assign boundary = ~lt & left.lt;
  assign hit      = boundary & valid_r & (value_r == ctl.value);

  assign stat.value = value_r;
  assign stat.valid = valid_r;
  assign stat.lt    = lt;

  // Insert opens a gap at the boundary; remove closes it from the right.
  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.ins_en && !lt) begin
      if (left.lt) begin
        value_nxt = ctl.value;
        valid_nxt = 1'b1;
      end else begin
        value_nxt = left.value;
        valid_nxt = left.valid;
      end
    end else if (ctl.rem_en && !lt) begin
      value_nxt = right.value;
      valid_nxt = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/sorted_list_engine_unit.sv =====
// Sorted list engine: holds up to CAPACITY signed 32-bit values in ascending
// order in a row of cells, each holding one entry. Every request (insert,
// remove first equal, find position) is compared against all cells at once
// and the row shifts in the same cycle; the result appears in the output
// register in the next cycle. With the result taken promptly the block
// accepts one request per cycle. The path that sets the clock is the 32-bit
// compare in every cell followed by the OR of the match flags that gates the
// remove shift. Reset empties the list at once.
`default_nettype none

`include "sorted_list_engine_unit_defines.svh"

module sorted_list_engine_unit #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sle_in_if.sink      in_chan,
  sle_out_if.source   out_chan
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sle_pkg::cell_ctl_t  ctl;
  sle_pkg::cell_stat_t stat [CAPACITY];
  sle_pkg::cell_stat_t head_stat;
  sle_pkg::cell_stat_t tail_stat;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] valid_vec;

  logic               accept;
  logic               full;
  logic               any_hit;
  logic [IW-1:0]      hit_idx;
  logic               is_ins, is_rem, is_find;

  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic [sle_pkg::POS_W-1:0]   pos_r, pos_nxt;
  logic [sle_pkg::COUNT_W-1:0] cnt_out_r;
  logic               empty_r;
  logic [IW+sle_pkg::POS_W-1:0]   pos_ext;
  logic [CW+sle_pkg::COUNT_W-1:0] cnt_ext;

  // Handshake: the output register frees up when its result is taken.
  // No request is taken while reset is held.
  assign in_chan.ready = rst_n & (~out_valid_r | out_chan.ready);
  assign accept        = in_chan.valid & in_chan.ready;

  // Command decode.
  always_comb begin
    is_ins  = 1'b0;
    is_rem  = 1'b0;
    is_find = 1'b0;
    unique case (sle_pkg::cmd_t'(in_chan.cmd))
      sle_pkg::CMD_INSERT: is_ins  = 1'b1;
      sle_pkg::CMD_REMOVE: is_rem  = 1'b1;
      sle_pkg::CMD_FIND:   is_find = 1'b1;
      default: ;
    endcase
  end

  assign full       = stat[CAPACITY-1].valid;
  assign any_hit    = |hit_vec;
  assign ctl.ins_en = accept & is_ins & ~full;
  assign ctl.rem_en = accept & is_rem & any_hit;
  assign ctl.value  = in_chan.value;

  // Ends of the row: nothing below the first cell, nothing after the last.
  assign head_stat = '{value: '0, valid: 1'b0, lt: 1'b1};
  assign tail_stat = '{value: '0, valid: 1'b0, lt: 1'b0};

  // The row of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      sle_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .left  (head_stat),
        .right (stat[1]),
        .stat  (stat[0]),
        .hit   (hit_vec[0])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      sle_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .left  (stat[i-1]),
        .right (tail_stat),
        .stat  (stat[i]),
        .hit   (hit_vec[i])
      );
    end else begin : g_mid
      sle_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .left  (stat[i-1]),
        .right (stat[i+1]),
        .stat  (stat[i]),
        .hit   (hit_vec[i])
      );
    end
    assign valid_vec[i] = stat[i].valid;
  end

  // At most one match flag is set, so its index is an OR of masked indexes.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  // Entry count after the request.
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.ins_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.rem_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Result fields; position and count keep their low bits.
  assign pos_ext = {{sle_pkg::POS_W{1'b0}}, hit_idx};
  assign cnt_ext = {{sle_pkg::COUNT_W{1'b0}}, cnt_nxt};

  always_comb begin
    ok_nxt        = ok_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      ok_nxt        = ctl.ins_en | ctl.rem_en | (is_find & any_hit);
      pos_nxt       = (is_find & any_hit) ? pos_ext[sle_pkg::POS_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r  <= ok_nxt;
    pos_r <= pos_nxt;
    if (accept) begin
      cnt_out_r <= cnt_ext[sle_pkg::COUNT_W-1:0];
      empty_r   <= (cnt_nxt == '0);
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.ok        = ok_r;
  assign out_chan.position  = pos_r;
  assign out_chan.count     = cnt_out_r;
  assign out_chan.empty_res = empty_r;

  // The count register shows a full list exactly when the last cell is filled.
  `SLE_ASSERT_SAME(a_full_matches_count, clk, rst_n, 1'b1,
                   (cnt_r == CW'(CAPACITY)) == full)
  // Filled cells always form a prefix of the row.
  `SLE_ASSERT_SAME(a_valid_prefix, clk, rst_n, 1'b1,
                   ((valid_vec + 1'b1) & valid_vec) == '0)
  // At most one cell reports the first equal entry.
  `SLE_ASSERT_SAME(a_single_hit, clk, rst_n, 1'b1, $onehot0(hit_vec))
  // A successful insert grows the list by one.
  `SLE_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.ins_en,
                   cnt_r == $past(cnt_r) + 1'b1)

endmodule

`default_nettype wire
